FILE: design/iirdf1_pkg.sv
`default_nettype none

package iirdf1_pkg;

  // default sizes
  localparam int FORWARD_TAPS_DEF  = 8;
  localparam int FEEDBACK_TAPS_DEF = 7;
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int COEF_BITS_DEF     = 48;

  // width of one multiplier digit
  localparam int DIG_BITS = 16;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORMALIZE_ON    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEAD_RECIPROCAL = 1'b1;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_FWD_COEF = 2'd1,
    OP_FBK_COEF = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_FWD  = 7'b0000010,
    ST_FBK  = 7'b0000100,
    ST_RND  = 7'b0001000,
    ST_NORM = 7'b0010000,
    ST_NRND = 7'b0100000,
    ST_SAT  = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

FILE: design/iir_direct_form_one_filter_top.sv
// direct form i iir filter, fixed point (samples q3.20, coefficients q6.41)
// input channel item_valid/item_ready carries opcode, coef_index, coef_value
// and sample; a transfer with a sample opcode starts one filter step, the other
// opcodes write a feed-forward or feedback coefficient or clear both histories
// and finish in the cycle of their transfer, giving no result
// result channel result_valid/result_ready carries filtered and saturated
// a sample runs through the forward taps, the feedback taps and rounding, then,
// when normalize_on is set, the normalizing product and its rounding, and last
// saturation; item_ready rises with result_valid, so a sample is taken only
// after the one before it is through, the pace being set by the single shared
// coefficient-by-16-bit-digit multiply-accumulate that walks every tap digit
// by digit and then the normalizing product
// the result sits in an output register: a new item is taken while it waits,
// and only when the next result is due does the block hold until the
// receiver has taken the previous one
// configuration: cfg_we with cfg_index and cfg_data writes a register at once
// reset (synchronous, active high) clears histories, coefficients, the result
// slot and sets normalize_on to 0 and lead_reciprocal to one
`default_nettype none

module iir_direct_form_one_filter_top #(
  parameter int FORWARD_TAPS  = iirdf1_pkg::FORWARD_TAPS_DEF,
  parameter int FEEDBACK_TAPS = iirdf1_pkg::FEEDBACK_TAPS_DEF,
  parameter int SAMPLE_BITS   = iirdf1_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS     = iirdf1_pkg::COEF_BITS_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst,
  // configuration
  input  wire                                      cfg_we,
  input  wire  [iirdf1_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire  [COEF_BITS-2:0]                     cfg_data,
  // input items
  input  wire                                      item_valid,
  output logic                                     item_ready,
  input  wire  [1:0]                               opcode,
  input  wire  [2:0]                               coef_index,
  input  wire  signed [COEF_BITS-1:0]              coef_value,
  input  wire  signed [SAMPLE_BITS-1:0]            sample,
  // results
  output logic                                     result_valid,
  input  wire                                      result_ready,
  output logic signed [SAMPLE_BITS-1:0]            filtered,
  output logic                                     saturated
);

  localparam int HB       = SAMPLE_BITS + 16;          // output history width
  localparam int CF       = COEF_BITS - 7;             // coefficient fraction bits
  localparam int SUM_BITS = COEF_BITS + HB + 6;        // exact tap sum
  localparam int RND_BITS = SUM_BITS - CF;             // sum after rounding
  localparam int ACC_BITS = RND_BITS + COEF_BITS;      // also holds normalizing product
  localparam int WV_BITS  = ACC_BITS - CF;
  localparam int DB       = iirdf1_pkg::DIG_BITS;
  localparam int NDIG     = (RND_BITS + DB - 1) / DB;
  localparam int PAD_BITS = NDIG * DB;
  localparam int DIG_W    = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int MAXT     = (FORWARD_TAPS > FEEDBACK_TAPS) ? FORWARD_TAPS : FEEDBACK_TAPS;
  localparam int TAP_W    = (MAXT > 1) ? $clog2(MAXT) : 1;
  localparam int FT_IW    = (FORWARD_TAPS > 1) ? $clog2(FORWARD_TAPS) : 1;
  localparam int FB_IW    = (FEEDBACK_TAPS > 1) ? $clog2(FEEDBACK_TAPS) : 1;

  localparam logic [DIG_W-1:0] FWD_DLAST = DIG_W'((SAMPLE_BITS + DB - 1) / DB - 1);
  localparam logic [DIG_W-1:0] FBK_DLAST = DIG_W'((HB + DB - 1) / DB - 1);
  localparam logic [DIG_W-1:0] NRM_DLAST = DIG_W'(NDIG - 1);
  localparam logic [TAP_W-1:0] FT_LAST   = TAP_W'(FORWARD_TAPS - 1);
  localparam logic [TAP_W-1:0] FB_LAST   = TAP_W'(FEEDBACK_TAPS - 1);

  localparam logic [ACC_BITS-1:0]    HALF     = ACC_BITS'(1) << (CF - 1);
  localparam logic [COEF_BITS-2:0]   LEAD_ONE = (COEF_BITS - 1)'(1) << CF;
  localparam logic [SAMPLE_BITS-1:0] OUT_MAX  = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] OUT_MIN  = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // filter state
  logic signed [SAMPLE_BITS-1:0] x_hist [FORWARD_TAPS];
  logic signed [HB-1:0]          y_hist [FEEDBACK_TAPS];
  logic signed [COEF_BITS-1:0]   b_coef [FORWARD_TAPS];
  logic signed [COEF_BITS-1:0]   a_coef [FEEDBACK_TAPS];

  // configuration registers
  logic                 normalize_on;
  logic [COEF_BITS-2:0] lead_reciprocal;

  // sequencer
  iirdf1_pkg::state_t state;
  logic [TAP_W-1:0]   tap;
  logic [DIG_W-1:0]   dig;

  // datapath
  logic signed [ACC_BITS-1:0] acc;
  logic signed [ACC_BITS-1:0] acc_next;
  logic signed [WV_BITS-1:0]  wval;

  logic signed [COEF_BITS-1:0]    op_a;
  logic signed [PAD_BITS-1:0]     op_b;
  logic                           dig_is_top;
  logic                           acc_sub;
  logic [DB-1:0]                  chunk;
  logic signed [DB:0]             dig_s;
  logic signed [COEF_BITS+DB:0]   prod;
  logic signed [ACC_BITS-1:0]     term;
  logic [ACC_BITS-1:0]            rnd_full;

  logic [WV_BITS-HB:0]            y_upper;
  logic                           y_clip;
  logic signed [HB-1:0]           y_val;
  logic [HB-SAMPLE_BITS:0]        o_upper;
  logic                           o_clip;
  logic signed [SAMPLE_BITS-1:0]  o_val;

  iirdf1_pkg::opcode_t op;
  logic                item_xfer;
  logic                result_load;
  logic [FT_IW-1:0]    fwd_widx;
  logic [FB_IW-1:0]    fbk_widx;

  assign op        = iirdf1_pkg::opcode_t'(opcode);
  assign item_ready = (state == iirdf1_pkg::ST_IDLE);
  assign item_xfer = item_valid && item_ready;
  assign fwd_widx  = FT_IW'(coef_index);
  assign fbk_widx  = FB_IW'(coef_index - 3'd1);

  // operand selection for the shared multiplier
  always_comb begin
    op_a       = b_coef[tap[FT_IW-1:0]];
    op_b       = PAD_BITS'(x_hist[tap[FT_IW-1:0]]);
    dig_is_top = (dig == FWD_DLAST);
    acc_sub    = 1'b0;
    unique case (state)
      iirdf1_pkg::ST_FBK: begin
        op_a       = a_coef[tap[FB_IW-1:0]];
        op_b       = PAD_BITS'(y_hist[tap[FB_IW-1:0]]);
        dig_is_top = (dig == FBK_DLAST);
        acc_sub    = 1'b1;
      end
      iirdf1_pkg::ST_NORM: begin
        op_a       = signed'({1'b0, lead_reciprocal});
        op_b       = PAD_BITS'(signed'(wval[RND_BITS-1:0]));
        dig_is_top = (dig == NRM_DLAST);
      end
      default: ;
    endcase
  end

  // one coefficient by one digit, shifted into place and accumulated;
  // the top digit of each operand is signed, the others unsigned
  always_comb begin
    chunk    = op_b[32'(dig) * DB +: DB];
    dig_s    = signed'({dig_is_top & chunk[DB-1], chunk});
    prod     = (COEF_BITS + DB + 1)'(op_a) * (COEF_BITS + DB + 1)'(dig_s);
    term     = ACC_BITS'(prod) << (32'(dig) * DB);
    acc_next = acc_sub ? (acc - term) : (acc + term);
    rnd_full = acc + HALF;
  end

  // saturate to the history width, then to the sample width
  always_comb begin
    y_upper = wval[WV_BITS-1:HB-1];
    y_clip  = !((&y_upper) || !(|y_upper));
    y_val   = y_clip ? (wval[WV_BITS-1] ? {1'b1, {(HB - 1){1'b0}}} : {1'b0, {(HB - 1){1'b1}}})
                     : wval[HB-1:0];
    o_upper = y_val[HB-1:SAMPLE_BITS-1];
    o_clip  = !((&o_upper) || !(|o_upper));
    o_val   = o_clip ? (y_val[HB-1] ? OUT_MIN : OUT_MAX) : y_val[SAMPLE_BITS-1:0];
  end

  assign result_load = (state == iirdf1_pkg::ST_SAT) && (!result_valid || result_ready);

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= iirdf1_pkg::ST_IDLE;
      tap             <= '0;
      dig             <= '0;
      result_valid    <= 1'b0;
      normalize_on    <= 1'b0;
      lead_reciprocal <= LEAD_ONE;
      for (int i = 0; i < FORWARD_TAPS; i++) begin
        x_hist[i] <= '0;
        b_coef[i] <= '0;
      end
      for (int i = 0; i < FEEDBACK_TAPS; i++) begin
        y_hist[i] <= '0;
        a_coef[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          iirdf1_pkg::REG_NORMALIZE_ON:    normalize_on    <= cfg_data[0];
          iirdf1_pkg::REG_LEAD_RECIPROCAL: lead_reciprocal <= cfg_data;
          default: ;
        endcase
      end

      if (result_valid && result_ready && !result_load) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        iirdf1_pkg::ST_IDLE: begin
          if (item_xfer) begin
            unique case (op)
              iirdf1_pkg::OP_SAMPLE: begin
                for (int i = FORWARD_TAPS - 1; i > 0; i--) begin
                  x_hist[i] <= x_hist[i-1];
                end
                x_hist[0] <= sample;
                acc       <= '0;
                tap       <= '0;
                dig       <= '0;
                state     <= iirdf1_pkg::ST_FWD;
              end
              iirdf1_pkg::OP_FWD_COEF: begin
                if (32'(coef_index) < FORWARD_TAPS) begin
                  b_coef[fwd_widx] <= coef_value;
                end
              end
              iirdf1_pkg::OP_FBK_COEF: begin
                if (coef_index != 3'd0 && 32'(coef_index) <= FEEDBACK_TAPS) begin
                  a_coef[fbk_widx] <= coef_value;
                end
              end
              iirdf1_pkg::OP_CLEAR: begin
                for (int i = 0; i < FORWARD_TAPS; i++) begin
                  x_hist[i] <= '0;
                end
                for (int i = 0; i < FEEDBACK_TAPS; i++) begin
                  y_hist[i] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        iirdf1_pkg::ST_FWD: begin
          acc <= acc_next;
          if (dig_is_top) begin
            dig <= '0;
            if (tap == FT_LAST) begin
              tap   <= '0;
              state <= iirdf1_pkg::ST_FBK;
            end else begin
              tap <= tap + 1'b1;
            end
          end else begin
            dig <= dig + 1'b1;
          end
        end
        iirdf1_pkg::ST_FBK: begin
          acc <= acc_next;
          if (dig_is_top) begin
            dig <= '0;
            if (tap == FB_LAST) begin
              tap   <= '0;
              state <= iirdf1_pkg::ST_RND;
            end else begin
              tap <= tap + 1'b1;
            end
          end else begin
            dig <= dig + 1'b1;
          end
        end
        iirdf1_pkg::ST_RND: begin
          // round half up to the sample fraction
          wval <= rnd_full[ACC_BITS-1:CF];
          if (normalize_on) begin
            acc   <= '0;
            dig   <= '0;
            state <= iirdf1_pkg::ST_NORM;
          end else begin
            state <= iirdf1_pkg::ST_SAT;
          end
        end
        iirdf1_pkg::ST_NORM: begin
          // rounded sum stays below 64 bits, so its 64-bit clamp never acts
          acc <= acc_next;
          if (dig_is_top) begin
            dig   <= '0;
            state <= iirdf1_pkg::ST_NRND;
          end else begin
            dig <= dig + 1'b1;
          end
        end
        iirdf1_pkg::ST_NRND: begin
          wval  <= rnd_full[ACC_BITS-1:CF];
          state <= iirdf1_pkg::ST_SAT;
        end
        iirdf1_pkg::ST_SAT: begin
          // hold here until the result slot is free
          if (result_load) begin
            for (int i = FEEDBACK_TAPS - 1; i > 0; i--) begin
              y_hist[i] <= y_hist[i-1];
            end
            y_hist[0]    <= y_val;
            filtered     <= o_val;
            saturated    <= o_clip;
            result_valid <= 1'b1;
            state        <= iirdf1_pkg::ST_IDLE;
          end
        end
        default: state <= iirdf1_pkg::ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a sample transfer starts the forward pass from a clean accumulator
  assert property (@(posedge clk) disable iff (rst)
    item_xfer && (op == iirdf1_pkg::OP_SAMPLE)
      |=> (state == iirdf1_pkg::ST_FWD) && (acc == '0) && (tap == '0) && (dig == '0))
    else $error("sample transfer did not start the forward pass");

  // coefficient writes and clears leave the sequencer idle in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    item_xfer && (op != iirdf1_pkg::OP_SAMPLE) |=> (state == iirdf1_pkg::ST_IDLE))
    else $error("non-sample item left the sequencer busy");

  // a clipped result sits at one of the range limits
  assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> (filtered == OUT_MAX) || (filtered == OUT_MIN))
    else $error("saturated flag without a limit value");

  // digit counter stays inside the sample operand during the forward pass
  assert property (@(posedge clk) disable iff (rst)
    (state == iirdf1_pkg::ST_FWD) |-> (dig <= FWD_DLAST))
    else $error("forward digit counter overran");

  // a result is only loaded from the final state
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == iirdf1_pkg::ST_SAT))
    else $error("result appeared outside the saturation step");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_iir_direct_form_one_filter_top.sv
`default_nettype none

module tb_iir_direct_form_one_filter_top;

  // block sizes, taken as built
  localparam int FT  = iirdf1_pkg::FORWARD_TAPS_DEF;
  localparam int FBT = iirdf1_pkg::FEEDBACK_TAPS_DEF;
  localparam int SB  = iirdf1_pkg::SAMPLE_BITS_DEF;
  localparam int CB  = iirdf1_pkg::COEF_BITS_DEF;
  localparam int CF  = CB - 7;          // coefficient fraction bits
  localparam int HB  = SB + 16;         // output history width
  localparam int CIB = iirdf1_pkg::CFG_INDEX_BITS;

  // coefficient, sample and reciprocal corner values
  localparam logic signed [CB-1:0] COEF_MAX   = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] COEF_MIN   = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [CB-2:0]        LEAD_ONE   = {{(CB-2){1'b0}}, 1'b1} << CF;
  localparam logic [CB-2:0]        LEAD_MAX   = {(CB-1){1'b1}};

  // run pacing
  localparam int SETTLE_CYCLES  = 64;
  localparam int LONG_HOLD      = 300;  // receiver hold-off, long enough to back up the input
  localparam int WATCHDOG_LIMIT = 4000; // cycles without any transfer
  localparam int PHASE_ITEMS    = 220;

  typedef struct packed {
    logic [SB-1:0] filtered;
    logic          saturated;
  } filter_result_t;

  // dut signals; the inputs are all known from time zero
  logic                       clk;
  logic                       rst          = 1'b1;
  logic                       cfg_we       = 1'b0;
  logic [CIB-1:0]             cfg_index    = iirdf1_pkg::REG_NORMALIZE_ON;
  logic [CB-2:0]              cfg_data     = '0;
  logic                       item_valid   = 1'b0;
  logic                       item_ready;
  logic [1:0]                 opcode       = iirdf1_pkg::OP_SAMPLE;
  logic [2:0]                 coef_index   = '0;
  logic signed [CB-1:0]       coef_value   = '0;
  logic signed [SB-1:0]       sample       = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  logic signed [SB-1:0]       filtered;
  logic                       saturated;

  // predictor state: histories, coefficients and register copies
  logic signed [SB-1:0] x_hist   [FT];
  logic signed [HB-1:0] y_hist   [FBT];
  logic signed [CB-1:0] fwd_coef [FT];
  logic signed [CB-1:0] fbk_coef [FBT];
  logic                 norm_on    = 1'b0;
  logic [CB-2:0]        lead_recip = LEAD_ONE;

  filter_result_t pending_outputs [$];   // outputs still owed by the block
  int             mismatch_count = 0;
  int             burst_left     = 0;
  logic           hold_results   = 1'b0; // asks the receiver for one long hold-off

  iir_direct_form_one_filter_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .opcode       (opcode),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .filtered     (filtered),
    .saturated    (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state starts as after reset
  initial begin : predictor_init
    int i;
    for (i = 0; i < FT; i++) begin
      x_hist[i]   = '0;
      fwd_coef[i] = '0;
    end
    for (i = 0; i < FBT; i++) begin
      y_hist[i]   = '0;
      fbk_coef[i] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // add half an lsb and drop the coefficient fraction, ties go upwards
  function automatic logic signed [127:0] round_q41(input logic signed [127:0] v);
    return (v + (128'sd1 <<< (CF - 1))) >>> CF;
  endfunction

  // clamp into a signed n-bit range, flag when clipped
  function automatic logic signed [127:0] clip_to(input logic signed [127:0] v,
                                                  input int n, output logic hit);
    logic signed [127:0] hi_lim, lo_lim;
    hi_lim = (128'sd1 <<< (n - 1)) - 128'sd1;
    lo_lim = -(128'sd1 <<< (n - 1));
    hit = 1'b0;
    if (v > hi_lim) begin
      hit = 1'b1;
      return hi_lim;
    end
    if (v < lo_lim) begin
      hit = 1'b1;
      return lo_lim;
    end
    return v;
  endfunction

  // one filter step: shift the sample in, exact multiply-accumulate, round,
  // optional normalising product, clamp to the history and then to the output
  function automatic filter_result_t filter_sample(input logic signed [SB-1:0] x);
    logic signed [127:0] acc, a, b, w;
    logic                dropped, clipped;
    filter_result_t      res;
    int                  i;
    for (i = FT - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
    x_hist[0] = x;
    acc = '0;
    for (i = 0; i < FT; i++) begin
      a = fwd_coef[i];
      b = x_hist[i];
      acc = acc + a * b;
    end
    for (i = 0; i < FBT; i++) begin
      a = fbk_coef[i];
      b = y_hist[i];
      acc = acc - a * b;
    end
    w = round_q41(acc);
    if (norm_on) begin
      w = clip_to(w, 64, dropped);
      b = lead_recip;
      w = round_q41(w * b);
    end
    w = clip_to(w, HB, dropped);
    for (i = FBT - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    y_hist[0] = w[HB-1:0];
    w = clip_to(w, SB, clipped);
    res.filtered  = w[SB-1:0];
    res.saturated = clipped;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random values
  // ---------------------------------------------------------------------------

  // tame values stay below a quarter so that a loaded filter rings rather
  // than pinning at the rails
  function automatic logic signed [CB-1:0] pick_coef(input logic tame);
    logic signed [63:0] r;
    r = {$urandom, $urandom};
    if (tame) begin
      r = r >>> $urandom_range(24, 28);
      return r[CB-1:0];
    end
    case ($urandom_range(0, 9))
      0, 1: return r[CB-1:0];
      2:    return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      3:    return '0;
      default: begin
        r = r >>> $urandom_range(22, 30);
        return r[CB-1:0];
      end
    endcase
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    logic signed [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return r[SB-1:0];
      5:    return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      6:    return '0;
      default: begin
        r = r >>> $urandom_range(41, 60);
        return r[SB-1:0];
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // shared driving tasks, all entered on a rising edge
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // offer one item, hold it until the transfer, then update the predictor;
  // valid is left high so that a following item goes straight on
  task automatic send_item(input iirdf1_pkg::opcode_t op, input logic [2:0] idx,
                           input logic signed [CB-1:0] cv,
                           input logic signed [SB-1:0] smp);
    int             i;
    filter_result_t owed;
    item_valid <= 1'b1;
    opcode     <= op;
    coef_index <= idx;
    coef_value <= cv;
    sample     <= smp;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    case (op)
      iirdf1_pkg::OP_SAMPLE: begin
        owed = filter_sample(smp);
        pending_outputs.insert(pending_outputs.size(), owed);
      end
      iirdf1_pkg::OP_FWD_COEF: if (int'(idx) < FT) fwd_coef[idx] = cv;
      // feedback taps count from one, index zero is dropped
      iirdf1_pkg::OP_FBK_COEF: if (idx >= 3'd1 && int'(idx) <= FBT) fbk_coef[idx - 3'd1] = cv;
      iirdf1_pkg::OP_CLEAR: begin
        for (i = 0; i < FT; i++) x_hist[i] = '0;
        for (i = 0; i < FBT; i++) y_hist[i] = '0;
      end
    endcase
  endtask

  task automatic pause_sender(input int cycles);
    item_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender pauses until every owed output is in, then lets the block go quiet
  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_register(input logic [CIB-1:0] index,
                                input logic [CB-2:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == iirdf1_pkg::REG_NORMALIZE_ON) norm_on = data[0];
    else lead_recip = data;
    @(posedge clk);
  endtask

  // bursts of random length, gaps of random length, some bursts run on
  // into the next without a gap
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 50));
      else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  // mostly samples; unused fields carry noise
  task automatic send_random_item();
    logic [63:0] r;
    int          roll;
    r    = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    pace_sender();
    if (roll < 74)
      send_item(iirdf1_pkg::OP_SAMPLE,   r[2:0], r[63:16],        pick_sample());
    else if (roll < 86)
      send_item(iirdf1_pkg::OP_FWD_COEF, r[2:0], pick_coef(1'b0), r[SB-1:0]);
    else if (roll < 97)
      send_item(iirdf1_pkg::OP_FBK_COEF, r[2:0], pick_coef(1'b0), r[SB-1:0]);
    else
      send_item(iirdf1_pkg::OP_CLEAR,    r[2:0], r[63:16],        r[SB+7:8]);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all coefficients zero after reset: output is zero, clear is harmless
  task automatic test_after_reset();
    send_item(iirdf1_pkg::OP_SAMPLE, 3'd0, COEF_MAX, SAMPLE_MAX);
    send_item(iirdf1_pkg::OP_CLEAR,  3'd7, COEF_MIN, SAMPLE_MIN);
  endtask

  // a product landing exactly on half an lsb rounds towards plus infinity
  task automatic test_rounding_ties();
    send_item(iirdf1_pkg::OP_FWD_COEF, 3'd0, 48'sd1 <<< 18, '0);
    send_item(iirdf1_pkg::OP_SAMPLE,   3'd0, '0, 24'sd1 <<< 22);
    send_item(iirdf1_pkg::OP_SAMPLE,   3'd0, '0, -(24'sd1 <<< 22));
  endtask

  // full-scale coefficients and samples, outer taps, ignored feedback index
  task automatic test_coef_extremes();
    send_item(iirdf1_pkg::OP_FWD_COEF, 3'd0, COEF_MAX, '0);
    send_item(iirdf1_pkg::OP_FWD_COEF, 3'd7, COEF_MIN, '0);
    send_item(iirdf1_pkg::OP_FBK_COEF, 3'd0, COEF_MAX, '0);
    send_item(iirdf1_pkg::OP_FBK_COEF, 3'd7, COEF_MIN, '0);
    send_item(iirdf1_pkg::OP_SAMPLE,   3'd0, '0, SAMPLE_MAX);
    send_item(iirdf1_pkg::OP_SAMPLE,   3'd0, '0, SAMPLE_MIN);
    send_item(iirdf1_pkg::OP_SAMPLE,   3'd0, '0, '0);
    send_item(iirdf1_pkg::OP_SAMPLE,   3'd0, '0, SAMPLE_MAX);
  endtask

  // strong positive feedback drives the output history into its clamp
  task automatic test_history_overflow();
    send_item(iirdf1_pkg::OP_CLEAR,    3'd0, '0, '0);
    send_item(iirdf1_pkg::OP_FBK_COEF, 3'd1, COEF_MIN, '0);
    repeat (4) send_item(iirdf1_pkg::OP_SAMPLE, 3'd0, '0, SAMPLE_MAX);
    send_item(iirdf1_pkg::OP_FBK_COEF, 3'd1, '0, '0);
    send_item(iirdf1_pkg::OP_FBK_COEF, 3'd7, '0, '0);
  endtask

  // new register setting, a fresh tame coefficient set, then random traffic
  task automatic test_random_phase(input logic norm, input logic [CB-2:0] lead,
                                   input logic write_lead);
    int i;
    wait_for_results();
    write_register(iirdf1_pkg::REG_NORMALIZE_ON, {{(CB-2){1'b0}}, norm});
    if (write_lead) write_register(iirdf1_pkg::REG_LEAD_RECIPROCAL, lead);
    for (i = 0; i < FT; i++)
      send_item(iirdf1_pkg::OP_FWD_COEF, 3'(i), pick_coef(1'b1), '0);
    for (i = 1; i <= FBT; i++)
      send_item(iirdf1_pkg::OP_FBK_COEF, 3'(i), pick_coef(1'b1), '0);
    repeat (PHASE_ITEMS) send_random_item();
  endtask

  // receiver holds off while samples keep coming, so the result slot fills
  // and the block has to stall its input
  task automatic test_receiver_hold();
    hold_results = 1'b1;
    repeat (12) send_item(iirdf1_pkg::OP_SAMPLE, 3'($urandom), pick_coef(1'b0), pick_sample());
  endtask

  // ---------------------------------------------------------------------------
  // processes
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [63:0] r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_rounding_ties();
    test_coef_extremes();
    test_history_overflow();
    test_random_phase(1'b0, LEAD_ONE, 1'b0);
    test_random_phase(1'b1, LEAD_ONE, 1'b1);
    test_receiver_hold();
    test_random_phase(1'b1, LEAD_MAX, 1'b1);
    test_random_phase(1'b1, '0, 1'b1);
    r = {$urandom, $urandom};
    test_random_phase(1'b1, r[CB-2:0] >> $urandom_range(0, 12), 1'b1);
    r = {$urandom, $urandom};
    test_random_phase(1'b0, r[CB-2:0], 1'b1);
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: stretches of always-ready, frequent, occasional and rare
  // ready, plus the one long hold-off on request
  initial begin : result_sink
    int stretch, pat;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        result_ready <= 1'b0;
        for (stretch = 0; stretch < LONG_HOLD; stretch++) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        pat     = $urandom_range(0, 3);
        stretch = $urandom_range(1, 40);
        repeat (stretch) begin
          case (pat)
            0:       result_ready <= 1'b1;
            1:       result_ready <= ($urandom_range(0, 3) != 0);
            2:       result_ready <= ($urandom_range(0, 1) != 0);
            default: result_ready <= ($urandom_range(0, 7) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // each output transfer against the oldest owed output, field by field
  always @(posedge clk) begin : result_check
    filter_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("output %h with nothing owed", filtered));
      end else begin
        want = pending_outputs.pop_front();
        if (filtered !== want.filtered)
          report_mismatch($sformatf("filtered %h, predicted %h", filtered, want.filtered));
        if (saturated !== want.saturated)
          report_mismatch($sformatf("saturated %b, predicted %b", saturated, want.saturated));
      end
    end
  end

  // ends a hung run: too many cycles without a transfer on either side
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
